// ===== rtl/cbss_pkg.sv =====
// ----------------------------------------------------------------------------
// cbss_pkg
// Types and constants shared by the block size selector.
// ----------------------------------------------------------------------------
package cbss_pkg;

    localparam int BASE_CACHE_BYTES_DEF    = 32768;
    localparam int MAX_SPLIT_TYPE_SIZE_DEF = 16;
    localparam int MIN_SPLIT_ELEMENTS_DEF  = 32;

    localparam int SIZE_W   = 31;
    localparam int TS_W     = 8;
    localparam int DIV_W    = 32;  // dividend padded to a whole number of steps
    localparam int DIV_STEP = 4;   // quotient bits per divider stage
    localparam int DIV_NSTG = DIV_W / DIV_STEP;
    localparam int LATENCY  = DIV_NSTG + 3;

    localparam logic [SIZE_W-1:0] SPLIT_MIN_BYTES = SIZE_W'(32 * 1024);
    localparam logic [SIZE_W-1:0] SPLIT_MAX_BYTES = SIZE_W'(4 * 1024 * 1024);
    localparam logic [3:0]        ZSTD_SPLIT_MAX_LEVEL = 4'd5;

    localparam logic [2:0] CODEC_FASTLZ = 3'd0;
    localparam logic [2:0] CODEC_LZ4    = 3'd1;
    localparam logic [2:0] CODEC_LZ4HC  = 3'd2;
    localparam logic [2:0] CODEC_ZLIB   = 3'd3;
    localparam logic [2:0] CODEC_ZSTD   = 3'd4;

    localparam logic [2:0] SPLIT_ALWAYS = 3'd0;
    localparam logic [2:0] SPLIT_NEVER  = 3'd1;

    typedef struct packed {
        logic [2:0]        codec;
        logic [3:0]        level;
        logic [TS_W-1:0]   type_size;
        logic [SIZE_W-1:0] source_bytes;
        logic [SIZE_W-1:0] user_block_size;
        logic [2:0]        split_policy;
        logic              shuffle_enabled;
    } t_req;

    typedef struct packed {
        logic [SIZE_W-1:0] block_size;
        logic              split_applied;
    } t_rsp;

    // word travelling from the sizing stages into the divider
    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] size;
        logic [TS_W-1:0]   ts;
        logic              split;
    } t_work;

endpackage

// ===== rtl/cbss_size.sv =====
// ----------------------------------------------------------------------------
// cbss_size
// Two pipeline stages: automatic size and split test, then split sizing
// and clamp to the source size.
// ----------------------------------------------------------------------------
module cbss_size
    import cbss_pkg::*;
#(
    parameter int BASE_CACHE_BYTES    = BASE_CACHE_BYTES_DEF,
    parameter int MAX_SPLIT_TYPE_SIZE = MAX_SPLIT_TYPE_SIZE_DEF,
    parameter int MIN_SPLIT_ELEMENTS  = MIN_SPLIT_ELEMENTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_req  i_req,
    output t_work o_work
);

    localparam logic [SIZE_W-1:0] BASE = SIZE_W'(BASE_CACHE_BYTES);
    localparam logic [TS_W-1:0]   MAXT = TS_W'(MAX_SPLIT_TYPE_SIZE);
    localparam logic [20:0]       MINE = 21'(MIN_SPLIT_ELEMENTS);

    // stage 1 registers
    logic              r_v1, n_v1;
    logic              r_small, r_user_nz, r_auto_ok, r_pol_always, r_pol_never;
    logic [3:0]        r_level;
    logic [TS_W-1:0]   r_ts;
    logic [SIZE_W-1:0] r_src, r_size;
    logic [20:0]       r_min_bytes;

    logic [TS_W-1:0]   ts;
    logic              hr;
    logic [SIZE_W-1:0] base, auto_size;

    always_comb begin
        ts = (i_req.type_size == '0) ? TS_W'(1) : i_req.type_size;
        hr = (i_req.codec == CODEC_LZ4HC) || (i_req.codec == CODEC_ZLIB) ||
             (i_req.codec == CODEC_ZSTD);
        base = hr ? (BASE << 1) : BASE;
        case (i_req.level)
            4'd0: auto_size = base >> 2;
            4'd1: auto_size = base >> 1;
            4'd3: auto_size = base << 1;
            4'd4, 4'd5: auto_size = base << 2;
            4'd6, 4'd7, 4'd8: auto_size = base << 3;
            4'd9: auto_size = hr ? (base << 4) : (base << 3);
            default: auto_size = base;
        endcase
        if (i_req.source_bytes < BASE) auto_size = i_req.source_bytes;
        n_v1 = i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
        end
        r_small      <= i_req.source_bytes < SIZE_W'(ts);
        r_user_nz    <= i_req.user_block_size != '0;
        r_size       <= (i_req.user_block_size != '0) ? i_req.user_block_size : auto_size;
        r_src        <= i_req.source_bytes;
        r_ts         <= ts;
        r_level      <= i_req.level;
        r_pol_always <= i_req.split_policy == SPLIT_ALWAYS;
        r_pol_never  <= i_req.split_policy == SPLIT_NEVER;
        r_auto_ok    <= ((i_req.codec == CODEC_FASTLZ) || (i_req.codec == CODEC_LZ4) ||
                         (i_req.codec == CODEC_ZSTD &&
                          i_req.level <= ZSTD_SPLIT_MAX_LEVEL)) &&
                        i_req.shuffle_enabled && (ts <= MAXT);
        r_min_bytes  <= MINE * 21'(ts);
    end

    // stage 2: split decision and sizing
    logic              wants, use_split;
    logic [SIZE_W-1:0] split_size, size2;
    t_work             r_out, n_out;

    always_comb begin
        if (r_pol_always)
            wants = 1'b1;
        else if (r_pol_never)
            wants = 1'b0;
        else
            wants = r_auto_ok && (r_size >= SIZE_W'(r_min_bytes));
        use_split = !r_small && !r_user_nz && (r_level != 4'd0) && wants;

        if (r_level <= 4'd3)      split_size = SIZE_W'(r_ts) << 15;
        else if (r_level <= 4'd6) split_size = SIZE_W'(r_ts) << 16;
        else if (r_level == 4'd7) split_size = SIZE_W'(r_ts) << 17;
        else if (r_level == 4'd8) split_size = SIZE_W'(r_ts) << 18;
        else                      split_size = SIZE_W'(r_ts) << 19;
        if (split_size > SPLIT_MAX_BYTES) split_size = SPLIT_MAX_BYTES;
        if (split_size < SPLIT_MIN_BYTES) split_size = SPLIT_MIN_BYTES;

        size2 = use_split ? split_size : r_size;
        if (size2 > r_src) size2 = r_src;
        if (r_small) size2 = SIZE_W'(1);

        n_out.valid = r_v1;
        n_out.size  = size2;
        n_out.ts    = r_ts;
        n_out.split = use_split;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= n_out.valid;
        end
        r_out.size  <= n_out.size;
        r_out.ts    <= n_out.ts;
        r_out.split <= n_out.split;
    end

    assign o_work = r_out;

endmodule

// ===== rtl/cbss_div.sv =====
// ----------------------------------------------------------------------------
// cbss_div
// Pipelined restoring remainder of size by ts, DIV_STEP bits per stage,
// then rounding down to a whole number of elements.
// ----------------------------------------------------------------------------
module cbss_div
    import cbss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_work i_work,
    output logic  o_done,
    output t_rsp  o_rsp
);

    t_work           r_stg [DIV_NSTG];
    logic [TS_W-1:0] r_rem [DIV_NSTG];
    logic [TS_W-1:0] n_rem [DIV_NSTG];

    // word and partial remainder entering each stage
    t_work           stg_in [DIV_NSTG];
    logic [TS_W-1:0] rem_in [DIV_NSTG];

    always_comb begin
        stg_in[0] = i_work;
        rem_in[0] = '0;
        for (int s = 1; s < DIV_NSTG; s++) begin
            stg_in[s] = r_stg[s-1];
            rem_in[s] = r_rem[s-1];
        end
    end

    always_comb begin
        for (int s = 0; s < DIV_NSTG; s++) begin
            logic [TS_W:0]    acc;
            logic [DIV_W-1:0] dvd;
            logic [TS_W-1:0]  d;
            acc = {1'b0, rem_in[s]};
            dvd = DIV_W'(stg_in[s].size);
            d   = stg_in[s].ts;
            for (int b = 0; b < DIV_STEP; b++) begin
                acc = {acc[TS_W-1:0], dvd[DIV_W-1-s*DIV_STEP-b]};
                if (acc >= {1'b0, d}) acc = acc - {1'b0, d};
            end
            n_rem[s] = acc[TS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_NSTG; s++) begin
            if (!i_rst_n) begin
                r_stg[s].valid <= 1'b0;
            end else begin
                r_stg[s].valid <= stg_in[s].valid;
            end
            r_stg[s].size  <= stg_in[s].size;
            r_stg[s].ts    <= stg_in[s].ts;
            r_stg[s].split <= stg_in[s].split;
            r_rem[s]       <= n_rem[s];
        end
    end

    t_work last;
    logic  r_done;
    t_rsp  r_rsp, n_rsp;

    always_comb begin
        last = r_stg[DIV_NSTG-1];
        n_rsp.split_applied = last.split;
        if (last.size > SIZE_W'(last.ts))
            n_rsp.block_size = last.size - SIZE_W'(r_rem[DIV_NSTG-1]);
        else
            n_rsp.block_size = last.size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= last.valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_rem_below_ts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last.valid |-> (r_rem[DIV_NSTG-1] < last.ts))
        else $error("remainder not below element size");
    a_ts_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_work.valid |-> (i_work.ts != '0))
        else $error("zero divisor entered divider");
    a_valid_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg[0].valid |=> r_stg[1].valid)
        else $error("valid bit lost in divider");

endmodule

// ===== rtl/compression_block_size_select.sv =====
// ----------------------------------------------------------------------------
// compression_block_size_select
// Chooses the compression block size for one buffer request.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_req and raise i_start for one cycle per request word; a word is
//   taken at each rising edge with i_start high and o_busy low. o_busy is
//   always low, so one word may be issued every cycle.
//   The result word appears on o_rsp with o_done high for exactly one cycle,
//   in request order.
//   Throughput is one word per cycle: two sizing stages, an eight-stage
//   remainder pipeline (four quotient bits per stage) and an output
//   register, all advancing every cycle.
//   The receiver cannot stall; each result must be taken when shown.
//   Synchronous reset clears all valid bits; words in flight are dropped
//   and o_done stays low until new words reach the end.
// ----------------------------------------------------------------------------
module compression_block_size_select
    import cbss_pkg::*;
#(
    parameter int BASE_CACHE_BYTES    = BASE_CACHE_BYTES_DEF,
    parameter int MAX_SPLIT_TYPE_SIZE = MAX_SPLIT_TYPE_SIZE_DEF,
    parameter int MIN_SPLIT_ELEMENTS  = MIN_SPLIT_ELEMENTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);

    t_work work;

    assign o_busy = 1'b0;

    cbss_size #(
        .BASE_CACHE_BYTES    (BASE_CACHE_BYTES),
        .MAX_SPLIT_TYPE_SIZE (MAX_SPLIT_TYPE_SIZE),
        .MIN_SPLIT_ELEMENTS  (MIN_SPLIT_ELEMENTS)
    ) u_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_req   (i_req),
        .o_work  (work)
    );

    cbss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (work),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LATENCY))
        else $error("result without matching request");
    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.block_size != '0))
        else $error("zero block size");
    a_split_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.split_applied) |-> (o_rsp.block_size <= SPLIT_MAX_BYTES))
        else $error("split size above limit");

endmodule

// ===== test/tb_compression_block_size_select.sv =====
// ----------------------------------------------------------------------------
// tb_compression_block_size_select
// Self-checking bench for the block size selector: directed corner words,
// then random requests, each result checked against a local predictor.
// ----------------------------------------------------------------------------
module tb_compression_block_size_select;
    import cbss_pkg::*;

    class size_scoreboard;
        t_rsp expected_q[$];
        int   n_errors;
        int   n_checked;
        int   n_split;

        function automatic t_rsp predict_size(t_req r);
            t_rsp             res;
            logic [63:0]      ts, src, sz;
            logic             hr, want;
            logic [63:0]      tbl;
            ts  = (r.type_size == 0) ? 64'd1 : 64'(r.type_size);
            src = 64'(r.source_bytes);
            res.split_applied = 1'b0;
            if (src < ts) begin
                res.block_size = SIZE_W'(1);
                return res;
            end
            if (r.user_block_size != 0) begin
                sz = 64'(r.user_block_size);
            end else begin
                sz = src;
                if (src >= BASE_CACHE_BYTES_DEF) begin
                    hr = (r.codec == CODEC_LZ4HC) || (r.codec == CODEC_ZLIB)
                         || (r.codec == CODEC_ZSTD);
                    sz = BASE_CACHE_BYTES_DEF;
                    if (hr) sz = sz * 2;
                    case (r.level)
                        4'd0: sz = sz / 4;
                        4'd1: sz = sz / 2;
                        4'd3: sz = sz * 2;
                        4'd4, 4'd5: sz = sz * 4;
                        4'd6, 4'd7, 4'd8: sz = sz * 8;
                        4'd9: sz = hr ? sz * 16 : sz * 8;
                        default: ;
                    endcase
                end
                if (r.split_policy == SPLIT_ALWAYS) want = 1'b1;
                else if (r.split_policy == SPLIT_NEVER) want = 1'b0;
                else want = (r.codec == CODEC_FASTLZ || r.codec == CODEC_LZ4
                             || (r.codec == CODEC_ZSTD && r.level <= ZSTD_SPLIT_MAX_LEVEL))
                            && r.shuffle_enabled && ts <= MAX_SPLIT_TYPE_SIZE_DEF
                            && (sz / ts) >= MIN_SPLIT_ELEMENTS_DEF;
                if (r.level != 0 && want) begin
                    res.split_applied = 1'b1;
                    if (r.level <= 3) tbl = 32 * 1024;
                    else if (r.level <= 6) tbl = 64 * 1024;
                    else if (r.level == 7) tbl = 128 * 1024;
                    else if (r.level == 8) tbl = 256 * 1024;
                    else tbl = 512 * 1024;
                    sz = tbl * ts;
                    if (sz > 64'(SPLIT_MAX_BYTES)) sz = 64'(SPLIT_MAX_BYTES);
                    if (sz < 64'(SPLIT_MIN_BYTES)) sz = 64'(SPLIT_MIN_BYTES);
                end
            end
            if (sz > src) sz = src;
            if (sz > ts) sz = sz / ts * ts;
            res.block_size = sz[SIZE_W-1:0];
            return res;
        endfunction

        function void note_request(t_req r);
            expected_q.push_back(predict_size(r));
        endfunction

        task check_result(t_rsp got);
            t_rsp exp_w;
            if (expected_q.size() == 0) begin
                report_mismatch("result word with nothing expected");
                return;
            end
            exp_w = expected_q.pop_front();
            n_checked++;
            if (got.split_applied) n_split++;
            if (got.block_size !== exp_w.block_size)
                report_mismatch($sformatf("block_size got %0d exp %0d",
                                          got.block_size, exp_w.block_size));
            if (got.split_applied !== exp_w.split_applied)
                report_mismatch($sformatf("split_applied got %0b exp %0b",
                                          got.split_applied, exp_w.split_applied));
        endtask

        task report_mismatch(string msg);
            n_errors++;
            $display("mismatch: %s", msg);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_done;
    t_rsp o_rsp;

    size_scoreboard sb;
    int             n_sent;

    compression_block_size_select u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) sb.note_request(i_req);
            if (o_done) sb.check_result(o_rsp);
        end
    end

    // one word: hold start until taken, with optional idle gap before it
    task automatic send_word(t_req r, bit may_idle);
        while (may_idle && $urandom_range(99) < 24) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        n_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [SIZE_W-1:0] rand_size();
        case ($urandom_range(5))
            0: return SIZE_W'($urandom_range(300));
            1: return SIZE_W'($urandom_range(70000));
            2: return SIZE_W'($urandom_range(8000000));
            3: return SIZE_W'($urandom);
            4: return SIZE_W'(32768 + $urandom_range(3) - 1);
            default: return SIZE_W'(1) << $urandom_range(30);
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.codec           = 3'($urandom_range(7));
        r.level           = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                     : 4'($urandom_range(9));
        r.type_size       = ($urandom_range(3) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(17));
        r.source_bytes    = rand_size();
        r.user_block_size = ($urandom_range(3) == 0) ? rand_size() : '0;
        r.split_policy    = 3'($urandom_range(7));
        r.shuffle_enabled = 1'($urandom);
        return r;
    endfunction

    function automatic t_req mk(logic [2:0] c, logic [3:0] l, logic [7:0] t,
                                logic [SIZE_W-1:0] s, logic [SIZE_W-1:0] u,
                                logic [2:0] p, logic sh);
        t_req r;
        r = '{codec: c, level: l, type_size: t, source_bytes: s,
              user_block_size: u, split_policy: p, shuffle_enabled: sh};
        return r;
    endfunction

    initial begin
        int   wait_cnt;
        t_req r;
        sb      = new();
        n_sent  = 0;
        i_start = 1'b0;
        i_req   = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners
        send_word(mk(CODEC_FASTLZ, 4'd0, 8'd0, '0, '0, SPLIT_NEVER, 1'b0), 0);
        send_word(mk(CODEC_LZ4, 4'd5, 8'd255, 31'd100, '0, SPLIT_ALWAYS, 1'b1), 0);
        send_word(mk(CODEC_ZLIB, 4'd9, 8'd4, '1, '0, SPLIT_NEVER, 1'b0), 0);
        send_word(mk(CODEC_LZ4HC, 4'd9, 8'd8, '1, '1, 3'd7, 1'b1), 0);
        send_word(mk(CODEC_ZSTD, 4'd5, 8'd4, 31'd1000000, '0, 3'd3, 1'b1), 0);
        send_word(mk(CODEC_ZSTD, 4'd6, 8'd4, 31'd1000000, '0, 3'd3, 1'b1), 0);
        send_word(mk(CODEC_FASTLZ, 4'd15, 8'd3, 31'd9000000, '0, 3'd2, 1'b1), 0);
        send_word(mk(CODEC_LZ4, 4'd12, 8'd16, 31'd9000000, '0, SPLIT_ALWAYS, 1'b1), 0);
        send_word(mk(3'd7, 4'd9, 8'd17, 31'd9000000, '0, 3'd4, 1'b1), 0);
        send_word(mk(CODEC_LZ4, 4'd1, 8'd1, 31'd32767, '0, 3'd4, 1'b1), 0);
        send_word(mk(CODEC_LZ4, 4'd0, 8'd2, 31'd32768, '0, SPLIT_ALWAYS, 1'b1), 0);
        send_word(mk(CODEC_FASTLZ, 4'd9, 8'd255, '1, '0, SPLIT_ALWAYS, 1'b1), 0);
        send_word(mk(3'd5, 4'd3, 8'd7, 31'd500000, 31'd12345, 3'd2, 1'b0), 0);
        send_word(mk(CODEC_ZLIB, 4'd7, 8'd2, 31'd3, 31'd9, 3'd5, 1'b1), 0);
        send_word(mk(CODEC_LZ4HC, 4'd8, 8'd1, 31'd64, '0, 3'd6, 1'b1), 0);

        // random: middle stretch runs back to back with no idling
        for (int i = 0; i < 1950; i++) begin
            r = rand_req();
            send_word(r, !(i >= 700 && i < 1100));
        end
        i_start <= 1'b0;

        wait_cnt = 0;
        while (sb.expected_q.size() != 0 && wait_cnt < 1000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("sent %0d request words, checked %0d results (%0d split-sized)",
                 n_sent, sb.n_checked, sb.n_split);
        if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cbss_pkg.sv
rtl/cbss_size.sv
rtl/cbss_div.sv
rtl/compression_block_size_select.sv
test/tb_compression_block_size_select.sv
